// ===== hdl/lpt_pkg.sv =====
// shared types and constants for the ligature pair table lookup
`default_nettype none

package lpt_pkg;

   // request kinds
   localparam logic [1:0] CMD_WRITE   = 2'd0;
   localparam logic [1:0] CMD_COMBINE = 2'd1;
   localparam logic [1:0] CMD_EXPAND  = 2'd2;

   // codes at or below this value are never expanded
   localparam logic [20:0] ASCII_LIMIT = 21'h00007f;

   // width of the search bounds and scan index (holds counts up to 2048)
   localparam int CW = 12;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [9:0]  index;
      logic [20:0] code;
      logic [20:0] accent;
      logic [15:0] composed;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [15:0] code;
      logic [15:0] accent;
   } rsp_type;

   typedef struct packed {
      logic [15:0] first;
      logic [15:0] second;
      logic [15:0] comp;
   } entry_type;

   typedef struct packed {
      logic idle;
      logic done;
   } eng_status_type;

endpackage

`default_nettype wire

// ===== hdl/lpt_engine.sv =====
// pair table memory with binary search and linear expand scan
`default_nettype none

module lpt_engine #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start_i,
   input  wire logic                   take_i,
   input  wire lpt_pkg::req_type       req_i,
   input  wire logic [10:0]            entry_count_i,
   output lpt_pkg::eng_status_type     status_o,
   output lpt_pkg::rsp_type            result_o
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = lpt_pkg::CW;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_CHECK = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   lpt_pkg::entry_type mem [TABLE_DEPTH];
   lpt_pkg::entry_type rd_data_ff;

   logic [1:0]        state_ff, state_in;
   logic [CW-1:0]     lo_ff, lo_in;
   logic [CW-1:0]     hi_ff, hi_in;       // exclusive upper bound
   logic [CW-1:0]     idx_ff, idx_in;     // probe or scan index
   lpt_pkg::req_type  req_ff, req_in;
   lpt_pkg::rsp_type  result_ff, result_in;

   logic              rd_en;
   logic              wr_en;
   logic [CW-1:0]     rd_idx;
   logic [CW-1:0]     mid;
   logic [CW-1:0]     mid_sum;
   logic [CW-1:0]     idx_next;
   logic [CW-1:0]     active;
   logic [16:0]       count_wide;
   logic [16:0]       depth_wide;
   logic [AW+CW-1:0]  rd_wide;
   logic [AW+9:0]     wr_wide;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     wr_addr;
   logic              wr_in_range;
   logic [20:0]       v1, v2, vc;
   logic              pair_match;
   logic              pair_greater;
   lpt_pkg::entry_type wr_data;

   // searched count saturates at the table depth
   assign count_wide = 17'(entry_count_i);
   assign depth_wide = 17'(TABLE_DEPTH);
   assign active     = (count_wide > depth_wide) ? depth_wide[CW-1:0] : count_wide[CW-1:0];

   assign mid_sum  = lo_ff + hi_ff - CW'(1);
   assign mid      = mid_sum >> 1;
   assign rd_idx   = (req_ff.cmd == lpt_pkg::CMD_COMBINE) ? mid : idx_ff;
   assign idx_next = idx_ff + CW'(1);

   assign rd_wide = {{AW{1'b0}}, rd_idx};
   assign rd_addr = rd_wide[AW-1:0];
   assign wr_wide = {{AW{1'b0}}, req_i.index};
   assign wr_addr = wr_wide[AW-1:0];
   assign wr_in_range = 17'(req_i.index) < depth_wide;

   assign wr_data.first  = req_i.code[15:0];
   assign wr_data.second = req_i.accent[15:0];
   assign wr_data.comp   = req_i.composed;

   assign v1 = {5'b0, rd_data_ff.first};
   assign v2 = {5'b0, rd_data_ff.second};
   assign vc = {5'b0, rd_data_ff.comp};
   assign pair_match   = (v1 == req_ff.code) && (v2 == req_ff.accent);
   assign pair_greater = (v1 > req_ff.code) || ((v1 == req_ff.code) && (v2 > req_ff.accent));

   always_comb begin
      state_in  = state_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      idx_in    = idx_ff;
      req_in    = req_ff;
      result_in = result_ff;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start_i) begin
               req_in    = req_i;
               result_in = '0;
               lo_in     = '0;
               hi_in     = active;
               idx_in    = '0;
               unique case (req_i.cmd)
                  lpt_pkg::CMD_WRITE: begin
                     wr_en    = wr_in_range;
                     state_in = S_DONE;
                  end
                  lpt_pkg::CMD_COMBINE: begin
                     state_in = (active == '0) ? S_DONE : S_READ;
                  end
                  lpt_pkg::CMD_EXPAND: begin
                     state_in = ((req_i.code > lpt_pkg::ASCII_LIMIT) && (active != '0)) ?
                                S_READ : S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            idx_in   = rd_idx;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (req_ff.cmd == lpt_pkg::CMD_COMBINE) begin
               if (pair_match) begin
                  result_in.found = 1'b1;
                  result_in.code  = rd_data_ff.comp;
                  state_in        = S_DONE;
               end else if (pair_greater) begin
                  hi_in    = idx_ff;
                  state_in = (lo_ff < idx_ff) ? S_READ : S_DONE;
               end else begin
                  lo_in    = idx_next;
                  state_in = (idx_next < hi_ff) ? S_READ : S_DONE;
               end
            end else begin
               if (vc == req_ff.code) begin
                  result_in.found  = 1'b1;
                  result_in.code   = rd_data_ff.first;
                  result_in.accent = rd_data_ff.second;
                  state_in         = S_DONE;
               end else begin
                  idx_in   = idx_next;
                  state_in = (idx_next < active) ? S_READ : S_DONE;
               end
            end
         end
         S_DONE: begin
            if (take_i) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      idx_ff    <= idx_in;
      req_ff    <= req_in;
      result_ff <= result_in;
   end

   // single port table with a registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign status_o.idle = (state_ff == S_IDLE);
   assign status_o.done = (state_ff == S_DONE);
   assign result_o      = result_ff;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start_i |-> (state_ff == S_IDLE))
      else $error("request started while engine busy");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ && req_ff.cmd == lpt_pkg::CMD_COMBINE) |-> (lo_ff < hi_ff))
      else $error("binary search probing an empty window");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ && req_ff.cmd == lpt_pkg::CMD_EXPAND) |-> (idx_ff < active))
      else $error("expand scan beyond searched count");

   a_write_no_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && req_ff.cmd == lpt_pkg::CMD_WRITE) |-> !result_ff.found)
      else $error("write request reporting a match");

endmodule

`default_nettype wire

// ===== hdl/ligature_pair_table_lookup_top.sv =====
// top level of the ligature pair table lookup: stream ports, count register, output stage
`default_nettype none

// Ligature pair table lookup. The table holds up to TABLE_DEPTH 16-bit triples
// (first, second, composed), which the user must keep sorted by first then
// second; the block itself does not enforce it. A write request loads one slot,
// a combine request binary-searches the first entry_count entries for
// (code, accent), an expand request scans from slot 0 for the first entry whose
// composed value equals code (codes up to 0x7f return no match at once). Every
// request gives exactly one response. Timing is set by the single table read
// port with its registered read: each probe or scanned entry goes through a
// read state (address), then a check state (compare). A write or a lookup that
// reads nothing goes from acceptance straight to the done state. One request is
// worked on at a time; the next is taken once the previous result sits in the
// output register, even while that response waits for rsp_tready. A response
// held by rsp_tready keeps the next result in the engine and stalls the request
// side for as long. Table contents are undefined until written.
module ligature_pair_table_lookup_top #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // index[9:0], code[30:10], accent[51:31], composed[67:52]
   input  wire logic [1:0]  req_tuser,   // command[1:0]
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // result_code[15:0], result_accent[31:16]
   output logic [0:0]       rsp_tuser,   // found[0]
   // count register write port
   input  wire logic        csr_wr_en,
   input  wire logic [10:0] csr_wr_data
);

   logic [10:0]                 entry_count_ff;
   logic                        rsp_tvalid_ff, rsp_tvalid_in;
   lpt_pkg::rsp_type            rsp_data_ff;
   lpt_pkg::req_type            req;
   lpt_pkg::rsp_type            eng_result;
   lpt_pkg::eng_status_type     eng_status;
   logic                        req_fire;
   logic                        take;

   // unpack the request fields
   assign req.cmd      = req_tuser;
   assign req.index    = req_tdata[9:0];
   assign req.code     = req_tdata[30:10];
   assign req.accent   = req_tdata[51:31];
   assign req.composed = req_tdata[67:52];

   // new request only while the engine sits idle
   assign req_tready = eng_status.idle;
   assign req_fire   = req_tvalid & req_tready;

   // finished result moves into the output register when it is free or draining
   assign take = eng_status.done & (~rsp_tvalid_ff | rsp_tready);

   // searched entry count; the user must write it only while idle, the block itself does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_wr_en) begin
         entry_count_ff <= csr_wr_data;
      end
   end

   lpt_engine #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .start_i       (req_fire),
      .take_i        (take),
      .req_i         (req),
      .entry_count_i (entry_count_ff),
      .status_o      (eng_status),
      .result_o      (eng_result)
   );

   // output register
   assign rsp_tvalid_in = take | (rsp_tvalid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= eng_result;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_data_ff.accent, rsp_data_ff.code};
   assign rsp_tuser  = rsp_data_ff.found;

endmodule

`default_nettype wire
